>>> sv/stbs_pkg.sv
// shared constants and types for the sorted table binary search block
package stbs_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 8;
  localparam int ECNT_W      = 9;

  // request kinds carried in tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [1:0] CFG_ORDER_MODE  = 2'd1;

  // order modes
  localparam logic [1:0] MODE_ASC    = 2'd0;
  localparam logic [1:0] MODE_DESC   = 2'd1;
  localparam logic [1:0] MODE_DETECT = 2'd2;

  // search sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_DETECT,
    ST_FINISH
  } state_e;

endpackage

>>> sv/sorted_table_binary_search.sv
// sorted table binary search: table memory, search sequencer and result register
// a write request is taken in idle and gives no result
// a search probe: PROBE (read), CHECK (compare), DETECT (window end read) in detect mode
// up to log2(depth)+1 probes; the result register loads from the finish state
// a new request is taken only in idle; an unaccepted earlier result stalls the finish state
// reset clears sequencer, configuration and result valid; table undefined until written
module sorted_table_binary_search
  import stbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] entry_address, [39:8] data_value
  input  logic        s_axis_tuser,   // [0] opcode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] found_index
  output logic        m_axis_tuser,   // [0] found
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // configuration registers
  logic [ECNT_W-1:0] entry_count_q;
  logic [1:0]        order_mode_q;

  // sequencer state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  hp1_q, hp1_d;       // window end, exclusive
  logic [CNT_W-1:0]  mid_q, mid_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic signed [DATA_W-1:0] lo_word_q, lo_word_d;
  logic              hit_q, hit_d;

  // result register
  logic              m_valid_q, m_valid_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  index_q, index_d;

  // table memory
  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rd_a_q, rd_b_q;
  logic              ren_a, ren_b, wen;
  logic [ADDR_W-1:0] raddr_a, raddr_b, waddr;

  // request decode
  logic              s_fire;
  logic [7:0]        req_addr;
  logic signed [DATA_W-1:0] req_data;
  logic [CNT_W-1:0]  count_sat;
  logic [CNT_W-1:0]  mid_calc;
  logic              rising;
  logic              go_left;
  logic [CNT_W-1:0]  lo_upd, hp1_upd;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign req_addr      = s_axis_tdata[7:0];
  assign req_data      = s_axis_tdata[39:8];
  assign cfg_ready_o   = 1'b1;

  // count saturates at the table depth
  assign count_sat = (32'(entry_count_q) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                             : CNT_W'(entry_count_q);

  // probe point start + (end - 1 - start) / 2, with end exclusive
  assign mid_calc = lo_q + ((hp1_q - CNT_W'(1) - lo_q) >> 1);

  // table write port
  assign wen   = s_fire && (s_axis_tuser == OP_WRITE) &&
                 (32'(req_addr) < 32'(TABLE_DEPTH));
  assign waddr = ADDR_W'(req_addr);

  // read ports: mid on port a, window ends on port b
  assign ren_a   = (state_q == ST_PROBE);
  assign raddr_a = ADDR_W'(mid_calc);
  assign ren_b   = (state_q == ST_PROBE) || (state_q == ST_CHECK);
  assign raddr_b = (state_q == ST_PROBE) ? ADDR_W'(lo_q) : ADDR_W'(hp1_q - CNT_W'(1));

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= req_data;
    end
    if (ren_a) begin
      rd_a_q <= mem[raddr_a];
    end
    if (ren_b) begin
      rd_b_q <= mem[raddr_b];
    end
  end

  // search direction for this probe
  always_comb begin
    case (order_mode_q)
      MODE_ASC:  rising = 1'b1;
      MODE_DESC: rising = 1'b0;
      default:   rising = (state_q == ST_DETECT) ? (lo_word_q < rd_b_q) : 1'b1;
    endcase
  end

  // window update after a miss
  assign go_left = ((key_q < rd_a_q) == rising);
  assign lo_upd  = go_left ? lo_q : mid_q + CNT_W'(1);
  assign hp1_upd = go_left ? mid_q : hp1_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && (s_axis_tuser == OP_SEARCH)) begin
          state_d = (count_sat == '0) ? ST_FINISH : ST_PROBE;
        end
      end
      ST_PROBE: state_d = ST_CHECK;
      ST_CHECK: begin
        if (rd_a_q == key_q) begin
          state_d = ST_FINISH;
        end else if (order_mode_q[1]) begin
          state_d = ST_DETECT;
        end else begin
          state_d = (lo_upd < hp1_upd) ? ST_PROBE : ST_FINISH;
        end
      end
      ST_DETECT: state_d = (lo_upd < hp1_upd) ? ST_PROBE : ST_FINISH;
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    lo_d      = lo_q;
    hp1_d     = hp1_q;
    mid_d     = mid_q;
    key_d     = key_q;
    lo_word_d = lo_word_q;
    hit_d     = hit_q;
    m_valid_d = m_valid_q;
    found_d   = found_q;
    index_d   = index_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && (s_axis_tuser == OP_SEARCH)) begin
          lo_d  = '0;
          hp1_d = count_sat;
          key_d = req_data;
          hit_d = 1'b0;
        end
      end
      ST_PROBE: mid_d = mid_calc;
      ST_CHECK: begin
        lo_word_d = rd_b_q;
        if (rd_a_q == key_q) begin
          hit_d = 1'b1;
        end else if (!order_mode_q[1]) begin
          lo_d  = lo_upd;
          hp1_d = hp1_upd;
        end
      end
      ST_DETECT: begin
        lo_d  = lo_upd;
        hp1_d = hp1_upd;
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          found_d   = hit_q;
          index_d   = hit_q ? IDX_W'(mid_q) : '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      m_valid_q     <= 1'b0;
      entry_count_q <= '0;
      order_mode_q  <= MODE_ASC;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i[ECNT_W-1:0];
          CFG_ORDER_MODE:  order_mode_q  <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hp1_q     <= hp1_d;
    mid_q     <= mid_d;
    key_q     <= key_d;
    lo_word_q <= lo_word_d;
    hit_q     <= hit_d;
    found_q   <= found_d;
    index_q   <= index_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = index_q;
  assign m_axis_tuser  = found_q;

  // a probe is only issued on a non-empty window
  a_window_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (lo_q < hp1_q))
    else $error("probe issued on empty window");

  // window end never passes the table depth
  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) && (state_q != ST_FINISH) |-> (32'(hp1_q) <= 32'(TABLE_DEPTH)))
    else $error("window end beyond table depth");

  // a new result only comes out of the finish state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == ST_FINISH))
    else $error("result raised outside finish state");

  // a miss reports index zero
  a_miss_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !found_q) |-> (index_q == '0))
    else $error("miss with nonzero index");

endmodule
